/* sv/ifrt_pkg.sv */
// Shared types and codes for the IP range filter table.
package ifrt_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int ERR_W = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_SPAN = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [31:0] query_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             hit;
    logic [31:0]      hit_low;
    logic [31:0]      hit_high;
    logic [ERR_W-1:0] error_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
  } entry_t;

  typedef struct packed {
    logic le;
    logic eq;
  } cmp_t;

endpackage

/* sv/ip_range_filter_table_unit.sv */
// Top level: sorted IPv4 range table with insert, lookup and clear.
// Lookup: p binary-search probes (at most ceil(log2(n+1)) for n entries, all on
//   one shared comparator), a range check, then the response. Insert: span check,
//   search, then each entry above the slot moved up; clear and unused go straight to the response.
// Refused inserts: end below start stops after the span check, duplicate or full after the search. Busy drops
//   with done, so the next request may be presented while done is high; results never stall.
// Reset empties the table and zeroes the error count; no clearing pass needed.
module ip_range_filter_table_unit import ifrt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t result
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RANGE, S_SRCH, S_CMP, S_POST, S_SH_RD, S_SH_WR, S_RESP
  } state_t;

  state_t           state;
  req_t             cur;
  logic [CW-1:0]    count;
  logic [ERR_W-1:0] err_cnt;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    sh_idx;
  logic             found;
  logic             dup;
  entry_t           found_entry;
  logic [1:0]       status;
  logic             hit;

  logic [31:0] key;
  logic [31:0] cmp_a;
  logic [31:0] cmp_b;
  cmp_t        cmp_res;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;
  logic [CW-1:0] mid_next;
  logic [CW-1:0] sh_prev;

  assign key      = (cur.operation == OP_LOOKUP) ? cur.query_addr : cur.range_low;
  assign mid_next = lo + ((hi - lo) >> 1);
  assign sh_prev  = sh_idx - CW'(1);

  always_comb begin
    case (state)
      S_RANGE: begin
        cmp_a = cur.range_low;
        cmp_b = cur.range_high;
      end
      S_CMP: begin
        cmp_a = ram_rdata.start_addr;
        cmp_b = key;
      end
      default: begin
        cmp_a = key;
        cmp_b = found_entry.end_addr;
      end
    endcase
  end

  ifrt_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sh_idx[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = mid_next[AW-1:0];
    case (state)
      S_SH_RD: begin
        ram_raddr = sh_prev[AW-1:0];
        if (sh_idx <= lo) begin
          ram_we              = 1'b1;
          ram_waddr           = lo[AW-1:0];
          ram_wdata.start_addr = cur.range_low;
          ram_wdata.end_addr   = cur.range_high;
        end
      end
      S_SH_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  ifrt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
      err_cnt <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= req;
            busy   <= 1'b1;
            status <= ST_OK;
            hit    <= 1'b0;
            found  <= 1'b0;
            dup    <= 1'b0;
            lo     <= '0;
            hi     <= count;
            case (req.operation)
              OP_INSERT: state <= S_RANGE;
              OP_LOOKUP: state <= S_SRCH;
              OP_CLEAR: begin
                count   <= '0;
                err_cnt <= '0;
                state   <= S_RESP;
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_RANGE: begin
          if (!cmp_res.le) begin
            status <= ST_BAD_SPAN;
            if (err_cnt != '1) err_cnt <= err_cnt + ERR_W'(1);
            state <= S_RESP;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          // read at mid_next is issued this cycle
          mid <= mid_next;
          if (lo < hi) state <= S_CMP;
          else         state <= S_POST;
        end
        S_CMP: begin
          if (cmp_res.le) begin
            lo          <= mid + CW'(1);
            found       <= 1'b1;
            found_entry <= ram_rdata;
            dup         <= cmp_res.eq;
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_POST: begin
          if (cur.operation == OP_LOOKUP) begin
            hit   <= found && cmp_res.le;
            state <= S_RESP;
          end else if (dup) begin
            status <= ST_DUP;
            if (err_cnt != '1) err_cnt <= err_cnt + ERR_W'(1);
            state <= S_RESP;
          end else if (count >= CW'(TABLE_DEPTH)) begin
            status <= ST_FULL;
            if (err_cnt != '1) err_cnt <= err_cnt + ERR_W'(1);
            state <= S_RESP;
          end else begin
            sh_idx <= count;
            state  <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          if (sh_idx > lo) begin
            state <= S_SH_WR;
          end else begin
            // new entry lands at its sorted position this cycle
            count <= count + CW'(1);
            state <= S_RESP;
          end
        end
        S_SH_WR: begin
          sh_idx <= sh_prev;
          state  <= S_SH_RD;
        end
        S_RESP: begin
          done               <= 1'b1;
          busy               <= 1'b0;
          result.status      <= status;
          result.hit         <= hit;
          result.hit_low     <= hit ? found_entry.start_addr : 32'd0;
          result.hit_high    <= hit ? found_entry.end_addr : 32'd0;
          result.error_count <= err_cnt;
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* sv/ifrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ifrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ifrt_cmp.sv */
// Shared 32-bit magnitude and equality compare unit.
module ifrt_cmp import ifrt_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output cmp_t        res
);

  assign res.le = (a <= b);
  assign res.eq = (a == b);

endmodule

/* sv/ifrt_checker.sv */
// Port-level checks for the IP range filter table, bound to the top level.
module ifrt_checker import ifrt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done set after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted request did not raise busy");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe without a request in flight");

  a_refusal_no_hit: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> !result.hit)
    else $error("refused insert reports a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> (result.hit_low == 32'd0) && (result.hit_high == 32'd0))
    else $error("miss carries nonzero range");

endmodule

bind ip_range_filter_table_unit ifrt_checker u_ifrt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* bench/range_table_checker.sv */
`timescale 1ns / 1ps
// Request/response checker for the IP range table: predicts and compares.
module range_table_checker import ifrt_pkg::*; #(
  parameter int DEPTH = DEF_TABLE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t result,
  output int   mismatches,
  output int   pending
);

  logic [31:0]      range_lo [DEPTH];
  logic [31:0]      range_hi [DEPTH];
  int               n_ranges;
  logic [ERR_W-1:0] refusals;
  rsp_t             expected_rsp [$];

  // Count of stored ranges whose start is not above key.
  function automatic int ranges_not_above(logic [31:0] key);
    int lo_i;
    int hi_i;
    int mid;
    lo_i = 0;
    hi_i = n_ranges;
    while (lo_i < hi_i) begin
      mid = (lo_i + hi_i) / 2;
      if (range_lo[mid] <= key) lo_i = mid + 1;
      else hi_i = mid;
    end
    return lo_i;
  endfunction

  function automatic logic [1:0] insert_range(logic [31:0] lo, logic [31:0] hi);
    int pos;
    if (hi < lo) return ST_BAD_SPAN;
    pos = ranges_not_above(lo);
    if (pos > 0 && range_lo[pos-1] == lo) return ST_DUP;
    if (n_ranges >= DEPTH) return ST_FULL;
    for (int i = n_ranges; i > pos; i--) begin
      range_lo[i] = range_lo[i-1];
      range_hi[i] = range_hi[i-1];
    end
    range_lo[pos] = lo;
    range_hi[pos] = hi;
    n_ranges++;
    return ST_OK;
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t rsp;
    int   pos;
    rsp = '0;
    case (r.operation)
      OP_INSERT: begin
        rsp.status = insert_range(r.range_low, r.range_high);
        if (rsp.status != ST_OK && refusals != '1) refusals++;
      end
      OP_LOOKUP: begin
        pos = ranges_not_above(r.query_addr);
        // only the nearest start at or below the address counts
        if (pos > 0 && r.query_addr <= range_hi[pos-1]) begin
          rsp.hit      = 1'b1;
          rsp.hit_low  = range_lo[pos-1];
          rsp.hit_high = range_hi[pos-1];
        end
      end
      OP_CLEAR: begin
        n_ranges = 0;
        refusals = '0;
      end
      default: ;
    endcase
    rsp.error_count = refusals;
    return rsp;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      n_ranges   = 0;
      refusals   = '0;
      mismatches = 0;
      expected_rsp.delete();
    end else begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = expected_rsp.pop_front();
          if (result.status !== want.status)
            report_mismatch($sformatf("status: got %0d, want %0d", result.status, want.status));
          if (result.hit !== want.hit)
            report_mismatch($sformatf("hit: got %0d, want %0d", result.hit, want.hit));
          if (result.hit_low !== want.hit_low)
            report_mismatch($sformatf("hit_low: got %h, want %h", result.hit_low,
                                      want.hit_low));
          if (result.hit_high !== want.hit_high)
            report_mismatch($sformatf("hit_high: got %h, want %h", result.hit_high,
                                      want.hit_high));
          if (result.error_count !== want.error_count)
            report_mismatch($sformatf("error_count: got %0d, want %0d", result.error_count,
                                      want.error_count));
        end
      end
      if (start && !busy) expected_rsp = {expected_rsp, predict_response(req)};
    end
    pending = expected_rsp.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Testbench top: drives requests into the IP range table and gives the verdict.
module testbench;
  import ifrt_pkg::*;

  localparam logic [1:0]  OP_UNUSED        = 2'd3;
  localparam int unsigned CYCLE_LIMIT      = 20_000_000;
  localparam int          RANDOM_PER_PHASE = 560;
  localparam int          POOL_MAX         = 200;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  req_t        req;
  rsp_t        result;
  int          mismatches;
  int          pending;
  int unsigned cycle_count = 0;
  int          gap_pct = 0;
  logic [31:0] addr_pool [$];

  ip_range_filter_table_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  range_table_checker rsp_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic req_t make_req(logic [1:0] op, logic [31:0] lo, logic [31:0] hi,
                                    logic [31:0] addr);
    req_t r;
    r.operation  = op;
    r.range_low  = lo;
    r.range_high = hi;
    r.query_addr = addr;
    return r;
  endfunction

  // Clamp lo + span at the top of the address space.
  function automatic logic [31:0] span_end(logic [31:0] lo, logic [31:0] span);
    logic [32:0] sum;
    sum = {1'b0, lo} + {1'b0, span};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Hold start low while busy or idling, then present the request for one edge.
  task automatic send_request(input req_t r);
    while (busy || $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(negedge clk);
  endtask

  task automatic pick_request(output req_t r);
    int unsigned roll;
    logic [31:0] base;
    logic [31:0] span;
    r.operation  = OP_LOOKUP;
    r.range_low  = $urandom;
    r.range_high = $urandom;
    r.query_addr = $urandom;
    if (addr_pool.size() != 0 && $urandom_range(3) != 0)
      base = addr_pool[$urandom_range(addr_pool.size() - 1)];
    else
      base = $urandom;
    span = $urandom_range(32'd1 << $urandom_range(20));
    roll = $urandom_range(999);
    if (roll < 4) begin
      r.operation = OP_CLEAR;
    end else if (roll < 24) begin
      r.operation = OP_UNUSED;
    end else if (roll < 480) begin
      r.operation = OP_INSERT;
      case ($urandom_range(9))
        0, 1: begin
          // reuse a known address to provoke duplicates
          r.range_low  = base;
          r.range_high = span_end(base, span);
        end
        2: begin
          if (r.range_low == 32'd0) r.range_low = 32'd1;
          r.range_high = $urandom_range(r.range_low - 32'd1);
        end
        3: ;
        4: begin
          r.range_low  = base + 32'($urandom_range(1, 16));
          r.range_high = span_end(r.range_low, span);
        end
        default: r.range_high = span_end(r.range_low, span);
      endcase
      addr_pool = {addr_pool, r.range_low, r.range_high};
      while (addr_pool.size() > POOL_MAX) void'(addr_pool.pop_front());
    end else begin
      case ($urandom_range(3))
        0:       ;
        1:       r.query_addr = base;
        default: r.query_addr = base + 32'($urandom_range(8)) - 32'd4;
      endcase
    end
  endtask

  initial begin
    req_t r;
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, refusals, extremes, overlap and gaps
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h0));
    send_request(make_req(OP_UNUSED, '1, '1, '1));
    send_request(make_req(OP_INSERT, 32'h10, 32'h20, 32'h0));
    send_request(make_req(OP_INSERT, 32'h10, 32'h30, 32'h0));
    send_request(make_req(OP_INSERT, 32'h50, 32'h40, 32'h0));
    send_request(make_req(OP_INSERT, 32'h50, 32'h50, 32'h0));
    send_request(make_req(OP_INSERT, 32'h0, 32'h0, 32'h0));
    send_request(make_req(OP_INSERT, '1, '1, 32'h0));
    send_request(make_req(OP_INSERT, 32'h30, 32'hFFFF_FFFE, 32'h0));
    send_request(make_req(OP_INSERT, 32'h40, 32'h45, 32'h0));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'hF));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h10));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h20));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h21));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h46));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, '1));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h0));
    send_request(make_req(OP_INSERT, '1, 32'h0, 32'h0));
    send_request(make_req(OP_CLEAR, '1, '1, '1));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h10));
    send_request(make_req(OP_INSERT, 32'h5, 32'hA, 32'h0));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h4));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'hA));

    // fill the table in ascending order, then hit every refusal while full
    send_request(make_req(OP_CLEAR, 32'h0, 32'h0, 32'h0));
    for (int i = 0; i < DEF_TABLE_DEPTH; i++)
      send_request(make_req(OP_INSERT, 32'(i) << 24, (32'(i) << 24) | 32'hFF, 32'h0));
    send_request(make_req(OP_INSERT, 32'h80, 32'h90, 32'h0));
    send_request(make_req(OP_INSERT, 32'h0100_0000, 32'h0100_0010, 32'h0));
    send_request(make_req(OP_INSERT, 32'h0100_0080, 32'h0100_0000, 32'h0));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h0500_0010));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, 32'h0500_01FF));
    send_request(make_req(OP_LOOKUP, 32'h0, 32'h0, '1));
    send_request(make_req(OP_CLEAR, 32'h0, 32'h0, 32'h0));

    // random phases: light sender gaps, heavy gaps, none
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 6 : (phase == 1) ? 77 : 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        pick_request(r);
        send_request(r);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
